// ----- rtl/core/pdtf_pkg.sv -----
// ----------------------------------------------------------------------------
// pdtf_pkg
// Types and constants shared by the PD transmit token framer.
// ----------------------------------------------------------------------------
package pdtf_pkg;

    localparam int NUM_REGS    = 8;
    localparam int MAX_RESULTS = 11;
    localparam int CFG_INDEX_W = 4;
    localparam int COUNT_W     = 4;
    localparam int COUNT_LSB   = 12;

    localparam logic [15:0] COUNT_FIELD_MASK = 16'h7000;
    localparam logic [4:0]  PACKSYM_LEN_MASK = 5'h1F;

    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_OBJECT = 1'b1;

    localparam logic [2:0] SOP_DEFAULT      = 3'd0;
    localparam logic [2:0] SOP_PRIME        = 3'd1;
    localparam logic [2:0] SOP_PRIME_DOUBLE = 3'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_SYNC1   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC2   = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC3   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PACKSYM = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC     = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_EOP     = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TXOFF   = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_TXON    = 4'd7;

    typedef enum logic [1:0] {
        FAULT_NONE       = 2'd0,
        FAULT_SOP        = 2'd1,
        FAULT_UNEXPECTED = 2'd2
    } t_fault;

    typedef struct packed {
        logic        operation;
        logic [2:0]  start_kind;
        logic [15:0] header_word;
        logic [2:0]  object_total;
        logic [31:0] object_word;
    } t_in_word;

    typedef struct packed {
        logic [7:0] token_byte;
        logic       last_of_run;
        t_fault     fault;
    } t_out_word;

    typedef struct packed {
        logic [7:0] sync_one;
        logic [7:0] sync_two;
        logic [7:0] sync_three;
        logic [7:0] packed_symbol;
        logic [7:0] crc;
        logic [7:0] end_packet;
        logic [7:0] transmit_off;
        logic [7:0] transmit_on;
    } t_tokens;

    typedef struct packed {
        logic [COUNT_W-1:0]                count;
        t_out_word [MAX_RESULTS-1:0]       slot;
    } t_job;

    typedef struct packed {
        logic [2:0] objects_left;
        logic       message_open;
    } t_msg_state;

endpackage

// ----- rtl/core/pd_message_tx_token_framer_core.sv -----
// ----------------------------------------------------------------------------
// pd_message_tx_token_framer_core
// USB PD transmit token framer: message words in, FIFO token bytes out.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready) takes header or object words. Each
// accepted word is planned in one pass into a run of 1 to 11 token words,
// held in a job register and shifted into the output register one per
// cycle while the receiver is ready. The output channel
// (o_out_valid/i_out_ready) carries one token byte per word, with
// last_of_run on the final word of each run and a fault code. An accepted
// word goes first to the job register and then, token by token, to the
// output register. A run has as many tokens as its word needs (header 1,
// 7 or 11; object 1, 4 or 8), and the next input word is taken in the
// cycle the last token of the current run moves to the output register.
// A stalled receiver holds the output register and the job register; input
// then waits. The config channel (i_cfg_valid/o_cfg_ready) is always ready;
// indexes beyond the token list are dropped.
// Reset loads the default token values, closes any message and empties
// the job and output registers.
// ----------------------------------------------------------------------------
module pd_message_tx_token_framer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  pdtf_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output pdtf_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pdtf_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [7:0]                          i_cfg_data
);
    import pdtf_pkg::*;

    t_tokens            r_tokens;
    t_msg_state         r_state;
    t_msg_state         n_state;
    t_job               r_job;
    t_job               n_job;
    logic               r_job_valid;
    logic [COUNT_W-1:0] r_idx;
    logic               r_out_valid;
    t_out_word          r_out;

    logic in_fire;
    logic out_free;
    logic move;
    logic job_done;

    pdtf_plan u_plan (
        .i_word   (i_in_word),
        .i_tokens (r_tokens),
        .i_state  (r_state),
        .o_job    (n_job),
        .o_state  (n_state)
    );

    assign out_free    = !r_out_valid || i_out_ready;
    assign move        = r_job_valid && out_free;
    assign job_done    = move && (r_idx == r_job.count - 4'd1);
    assign o_in_ready  = !r_job_valid || job_done;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tokens.sync_one      <= 8'd18;
            r_tokens.sync_two      <= 8'd19;
            r_tokens.sync_three    <= 8'd27;
            r_tokens.packed_symbol <= 8'd128;
            r_tokens.crc           <= 8'd255;
            r_tokens.end_packet    <= 8'd20;
            r_tokens.transmit_off  <= 8'd254;
            r_tokens.transmit_on   <= 8'd161;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SYNC1:   r_tokens.sync_one      <= i_cfg_data;
                REG_SYNC2:   r_tokens.sync_two      <= i_cfg_data;
                REG_SYNC3:   r_tokens.sync_three    <= i_cfg_data;
                REG_PACKSYM: r_tokens.packed_symbol <= i_cfg_data;
                REG_CRC:     r_tokens.crc           <= i_cfg_data;
                REG_EOP:     r_tokens.end_packet    <= i_cfg_data;
                REG_TXOFF:   r_tokens.transmit_off  <= i_cfg_data;
                REG_TXON:    r_tokens.transmit_on   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_job_valid <= 1'b0;
            r_idx       <= '0;
        end else if (in_fire) begin
            r_state     <= n_state;
            r_job_valid <= 1'b1;
            r_idx       <= '0;
        end else if (job_done) begin
            r_job_valid <= 1'b0;
        end else if (move) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_job <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= r_job.slot[r_idx];
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_job.count != 4'd0 && r_job.count <= 4'(MAX_RESULTS)))
        else $error("job token count out of range");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_idx < r_job.count))
        else $error("token index past end of run");

    a_open_matches_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.message_open == (r_state.objects_left != 3'd0))
        else $error("message open flag disagrees with objects left");

    a_last_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_done |=> (o_out_valid && o_out_word.last_of_run))
        else $error("final token of run not marked last");

    a_no_early_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && !job_done) |=> !o_out_word.last_of_run)
        else $error("token marked last before end of run");
`endif

endmodule

// ----- rtl/core/pdtf_plan.sv -----
// ----------------------------------------------------------------------------
// pdtf_plan
// Builds the full token run for one input word and the next message state.
// ----------------------------------------------------------------------------
module pdtf_plan (
    input  pdtf_pkg::t_in_word   i_word,
    input  pdtf_pkg::t_tokens    i_tokens,
    input  pdtf_pkg::t_msg_state i_state,
    output pdtf_pkg::t_job       o_job,
    output pdtf_pkg::t_msg_state o_state
);
    import pdtf_pkg::*;

    t_job        job;
    logic [15:0] header;
    logic [4:0]  byte_count;
    logic [2:0]  left_dec;

    assign header     = (i_word.header_word & ~COUNT_FIELD_MASK)
                      | (16'(i_word.object_total) << COUNT_LSB);
    assign byte_count = PACKSYM_LEN_MASK & (5'({i_word.object_total, 2'b00}) + 5'd2);
    assign left_dec   = i_state.objects_left - 3'd1;

    always_comb begin
        job     = '0;
        o_state = i_state;
        if (i_word.operation == OP_HEADER) begin
            o_state = '0;
            case (i_word.start_kind)
                SOP_DEFAULT: begin
                    job.slot[0].token_byte = i_tokens.sync_one;
                    job.slot[1].token_byte = i_tokens.sync_one;
                    job.slot[2].token_byte = i_tokens.sync_one;
                    job.slot[3].token_byte = i_tokens.sync_two;
                end
                SOP_PRIME: begin
                    job.slot[0].token_byte = i_tokens.sync_one;
                    job.slot[1].token_byte = i_tokens.sync_one;
                    job.slot[2].token_byte = i_tokens.sync_three;
                    job.slot[3].token_byte = i_tokens.sync_three;
                end
                SOP_PRIME_DOUBLE: begin
                    job.slot[0].token_byte = i_tokens.sync_one;
                    job.slot[1].token_byte = i_tokens.sync_three;
                    job.slot[2].token_byte = i_tokens.sync_one;
                    job.slot[3].token_byte = i_tokens.sync_three;
                end
                default: begin
                    job.slot[0].fault = FAULT_SOP;
                end
            endcase
            if (i_word.start_kind inside {SOP_DEFAULT, SOP_PRIME, SOP_PRIME_DOUBLE}) begin
                job.slot[4].token_byte = i_tokens.packed_symbol | {3'b000, byte_count};
                job.slot[5].token_byte = header[7:0];
                job.slot[6].token_byte = header[15:8];
                if (i_word.object_total == 3'd0) begin
                    job.slot[7].token_byte  = i_tokens.crc;
                    job.slot[8].token_byte  = i_tokens.end_packet;
                    job.slot[9].token_byte  = i_tokens.transmit_off;
                    job.slot[10].token_byte = i_tokens.transmit_on;
                    job.count               = 4'd11;
                end else begin
                    job.count            = 4'd7;
                    o_state.objects_left = i_word.object_total;
                    o_state.message_open = 1'b1;
                end
            end else begin
                job.count = 4'd1;
            end
        end else if (!i_state.message_open || i_state.objects_left == 3'd0) begin
            job.slot[0].fault = FAULT_UNEXPECTED;
            job.count         = 4'd1;
        end else begin
            job.slot[0].token_byte = i_word.object_word[7:0];
            job.slot[1].token_byte = i_word.object_word[15:8];
            job.slot[2].token_byte = i_word.object_word[23:16];
            job.slot[3].token_byte = i_word.object_word[31:24];
            o_state.objects_left   = left_dec;
            if (left_dec == 3'd0) begin
                o_state.message_open   = 1'b0;
                job.slot[4].token_byte = i_tokens.crc;
                job.slot[5].token_byte = i_tokens.end_packet;
                job.slot[6].token_byte = i_tokens.transmit_off;
                job.slot[7].token_byte = i_tokens.transmit_on;
                job.count              = 4'd8;
            end else begin
                job.count = 4'd4;
            end
        end
        for (int i = 0; i < MAX_RESULTS; i++) begin
            job.slot[i].last_of_run = (COUNT_W'(i) == job.count - 4'd1);
        end
    end

    assign o_job = job;

endmodule

// ----- bench/pdtf_token_checker.sv -----
// ----------------------------------------------------------------------------
// pdtf_token_checker
// Watches the framer's channels, predicts every token word and compares.
// ----------------------------------------------------------------------------
// Each accepted message word is framed by a local model with its own copy of
// the token registers and the open-message state. The expected token words
// are queued in order, and each accepted output word is checked field by
// field against the oldest one. The failure count, the number of token words
// still outstanding and a few totals go back to the bench top.
// ----------------------------------------------------------------------------
module pdtf_token_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  pdtf_pkg::t_in_word               i_in_word,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  pdtf_pkg::t_out_word              i_out_word,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [pdtf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]                       i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked,
    output int                               o_faults
);

    timeunit 1ns;
    timeprecision 1ps;

    import pdtf_pkg::*;

    localparam t_tokens TOKEN_DEFAULTS = {8'd18, 8'd19, 8'd27, 8'd128,
                                          8'd255, 8'd20, 8'd254, 8'd161};

    t_tokens     tok;
    logic [2:0]  objs_due;
    logic        msg_active;
    t_out_word   token_q [$];
    t_out_word   run_buf [MAX_RESULTS];
    int          run_len;
    int          fails;
    int          checked;
    int          faults;

    task automatic add_token(input logic [7:0] b, input t_fault f);
        run_buf[run_len].token_byte  = b;
        run_buf[run_len].last_of_run = 1'b0;
        run_buf[run_len].fault       = f;
        run_len = run_len + 1;
    endtask

    task automatic add_tail();
        add_token(tok.crc, FAULT_NONE);
        add_token(tok.end_packet, FAULT_NONE);
        add_token(tok.transmit_off, FAULT_NONE);
        add_token(tok.transmit_on, FAULT_NONE);
    endtask

    task automatic frame_word(input t_in_word w);
        logic [15:0] hdr;
        logic        sop_ok;
        t_out_word   tw;
        run_len = 0;
        if (w.operation == OP_HEADER) begin
            objs_due   = '0;
            msg_active = 1'b0;
            sop_ok     = 1'b1;
            case (w.start_kind)
                SOP_DEFAULT: begin
                    add_token(tok.sync_one, FAULT_NONE);
                    add_token(tok.sync_one, FAULT_NONE);
                    add_token(tok.sync_one, FAULT_NONE);
                    add_token(tok.sync_two, FAULT_NONE);
                end
                SOP_PRIME: begin
                    add_token(tok.sync_one, FAULT_NONE);
                    add_token(tok.sync_one, FAULT_NONE);
                    add_token(tok.sync_three, FAULT_NONE);
                    add_token(tok.sync_three, FAULT_NONE);
                end
                SOP_PRIME_DOUBLE: begin
                    add_token(tok.sync_one, FAULT_NONE);
                    add_token(tok.sync_three, FAULT_NONE);
                    add_token(tok.sync_one, FAULT_NONE);
                    add_token(tok.sync_three, FAULT_NONE);
                end
                default: begin
                    sop_ok = 1'b0;
                    add_token(8'h00, FAULT_SOP);
                end
            endcase
            if (sop_ok) begin
                hdr = (w.header_word & ~COUNT_FIELD_MASK)
                    | (16'(w.object_total) << COUNT_LSB);
                add_token(tok.packed_symbol
                          | {3'b000, PACKSYM_LEN_MASK & 5'(2 + 4 * w.object_total)},
                          FAULT_NONE);
                add_token(hdr[7:0], FAULT_NONE);
                add_token(hdr[15:8], FAULT_NONE);
                if (w.object_total == 3'd0) begin
                    add_tail();
                end else begin
                    objs_due   = w.object_total;
                    msg_active = 1'b1;
                end
            end
        end else if (!msg_active || objs_due == 3'd0) begin
            add_token(8'h00, FAULT_UNEXPECTED);
        end else begin
            add_token(w.object_word[7:0], FAULT_NONE);
            add_token(w.object_word[15:8], FAULT_NONE);
            add_token(w.object_word[23:16], FAULT_NONE);
            add_token(w.object_word[31:24], FAULT_NONE);
            objs_due = objs_due - 3'd1;
            if (objs_due == 3'd0) begin
                msg_active = 1'b0;
                add_tail();
            end
        end
        for (int i = 0; i < run_len; i++) begin
            tw = run_buf[i];
            tw.last_of_run = (i == run_len - 1);
            token_q.push_back(tw);
        end
    endtask

    initial begin
        fails   = 0;
        checked = 0;
        faults  = 0;
    end

    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            tok        = TOKEN_DEFAULTS;
            objs_due   = '0;
            msg_active = 1'b0;
            token_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SYNC1:   tok.sync_one      = i_cfg_data;
                    REG_SYNC2:   tok.sync_two      = i_cfg_data;
                    REG_SYNC3:   tok.sync_three    = i_cfg_data;
                    REG_PACKSYM: tok.packed_symbol = i_cfg_data;
                    REG_CRC:     tok.crc           = i_cfg_data;
                    REG_EOP:     tok.end_packet    = i_cfg_data;
                    REG_TXOFF:   tok.transmit_off  = i_cfg_data;
                    REG_TXON:    tok.transmit_on   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                checked = checked + 1;
                if (i_out_word.fault !== FAULT_NONE) begin
                    faults = faults + 1;
                end
                if (token_q.size() == 0) begin
                    fails = fails + 1;
                    $display("%0t: unexpected token word: byte %h last %b fault %0d",
                             $time, i_out_word.token_byte, i_out_word.last_of_run,
                             i_out_word.fault);
                end else begin
                    want = token_q.pop_front();
                    if (i_out_word.token_byte !== want.token_byte
                        || i_out_word.last_of_run !== want.last_of_run
                        || i_out_word.fault !== want.fault) begin
                        fails = fails + 1;
                        $display("%0t: byte/last/fault expected %h/%b/%0d, got %h/%b/%0d",
                                 $time, want.token_byte, want.last_of_run, want.fault,
                                 i_out_word.token_byte, i_out_word.last_of_run,
                                 i_out_word.fault);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                frame_word(i_in_word);
            end
        end
        o_pending    <= token_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
        o_faults     <= faults;
    end

endmodule

// ----- bench/pd_message_tx_token_framer_core_tb.sv -----
// ----------------------------------------------------------------------------
// pd_message_tx_token_framer_core_tb
// Stimulus and verdict for the PD transmit token framer.
// ----------------------------------------------------------------------------
// Runs a directed set of messages at the reset token values (every SOP type,
// bad SOP types, stray objects, abandoned messages, field extremes), then
// random message traffic under several token settings, all zeros and all
// ones among them. Both channels idle in random bursts except in the last
// phase. A checker beside the block predicts and compares every token word.
// ----------------------------------------------------------------------------
module pd_message_tx_token_framer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pdtf_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int TIMEOUT_NS = 3_000_000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_in_word               i_in_word;
    logic                   o_out_valid;
    logic                   i_out_ready;
    t_out_word              o_out_word;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [7:0]             i_cfg_data;

    int   fail_count;
    int   pending;
    int   checked;
    int   fault_words;
    int   header_sent;
    int   object_sent;
    int   settings;
    logic idle_on;

    pd_message_tx_token_framer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    pdtf_token_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_word   (o_out_word),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_faults     (fault_words)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_in_word make_header(input logic [2:0] kind,
                                             input logic [15:0] hw,
                                             input logic [2:0] total);
        t_in_word w;
        w.operation    = OP_HEADER;
        w.start_kind   = kind;
        w.header_word  = hw;
        w.object_total = total;
        w.object_word  = $urandom;
        return w;
    endfunction

    function automatic t_in_word make_object(input logic [31:0] data);
        t_in_word w;
        w.operation    = OP_OBJECT;
        w.start_kind   = 3'($urandom_range(0, 7));
        w.header_word  = 16'($urandom);
        w.object_total = 3'($urandom_range(0, 7));
        w.object_word  = data;
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        if (w.operation == OP_HEADER) begin
            header_sent = header_sent + 1;
        end else begin
            object_sent = object_sent + 1;
        end
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic program_tokens(input logic [8*NUM_REGS-1:0] vals);
        for (int i = 0; i < NUM_REGS; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_INDEX_W'(i);
            i_cfg_data  <= vals[8*(NUM_REGS-1-i) +: 8];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_index <= CFG_INDEX_W'($urandom_range(NUM_REGS, (1 << CFG_INDEX_W) - 1));
        i_cfg_data  <= 8'($urandom);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        settings = settings + 1;
    endtask

    task automatic random_traffic(input int n_words);
        int sent;
        int pick;
        int total;
        int cut;
        sent = 0;
        while (sent < n_words) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                send_word(make_header(3'($urandom_range(SOP_PRIME_DOUBLE + 1, 7)),
                                      16'($urandom), 3'($urandom_range(0, 7))));
                sent = sent + 1;
            end else if (pick == 1) begin
                send_word(make_object($urandom));
                sent = sent + 1;
            end else begin
                total = $urandom_range(0, 7);
                cut   = (pick == 2) ? $urandom_range(0, total) : total;
                send_word(make_header(3'($urandom_range(SOP_DEFAULT, SOP_PRIME_DOUBLE)),
                                      16'($urandom), 3'(total)));
                for (int k = 0; k < cut; k++) begin
                    send_word(make_object($urandom));
                end
                sent = sent + 1 + cut;
            end
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        idle_on     = 1'b1;
        header_sent = 0;
        object_sent = 0;
        settings    = 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(make_header(SOP_DEFAULT, 16'h0000, 3'd0));
        send_word(make_header(SOP_PRIME, 16'hFFFF, 3'd1));
        send_word(make_object(32'hFFFF_FFFF));
        send_word(make_header(SOP_PRIME_DOUBLE, 16'h8F5A, 3'd7));
        send_word(make_object(32'h0000_0000));
        send_word(make_object(32'h1234_5678));
        send_word(make_object(32'hFFFF_FFFF));
        send_word(make_object(32'h8000_0001));
        send_word(make_object(32'h7FFF_FFFE));
        send_word(make_object(32'hA5A5_5A5A));
        send_word(make_object(32'h5A5A_A5A5));
        send_word(make_object(32'hDEAD_BEEF));
        send_word(make_header(3'd3, 16'h1234, 3'd2));
        send_word(make_header(3'd7, 16'hFFFF, 3'd7));
        send_word(make_header(SOP_DEFAULT, 16'h7FFF, 3'd2));
        send_word(make_object(32'h0102_0304));
        send_word(make_header(SOP_PRIME, 16'h0FFF, 3'd0));
        send_word(make_object(32'hCAFE_F00D));
        send_word(make_header(SOP_PRIME_DOUBLE, 16'hF000, 3'd3));
        send_word(make_object(32'h1357_9BDF));
        send_word(make_header(3'd5, 16'h0000, 3'd0));
        send_word(make_object(32'h2468_ACE0));

        for (int phase = 0; phase < 4; phase++) begin
            drain_results();
            case (phase)
                0:       program_tokens({NUM_REGS{8'h00}});
                1:       program_tokens({NUM_REGS{8'hFF}});
                default: program_tokens({$urandom, $urandom});
            endcase
            if (phase == 3) begin
                idle_on = 1'b0;
            end
            random_traffic(32);
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d header and %0d object words under %0d token settings;",
                 header_sent, object_sent, settings);
        $display("checked %0d token words, %0d of them fault words.",
                 checked, fault_words);
        if (fail_count == 0 && pending == 0) begin
            $display("** pd_message_tx_token_framer_core: PASSED **");
        end else begin
            $display("** pd_message_tx_token_framer_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d token words outstanding", $time, pending);
        $display("** pd_message_tx_token_framer_core: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/pdtf_pkg.sv
rtl/core/pdtf_plan.sv
rtl/core/pd_message_tx_token_framer_core.sv
bench/pdtf_token_checker.sv
bench/pd_message_tx_token_framer_core_tb.sv
